// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/jsec_pkg.sv =====
// shared types, constants and character maps of the json string escape codec
package jsec_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	localparam logic MODE_ESCAPE   = 1'b0;
	localparam logic MODE_UNESCAPE = 1'b1;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] LT_N      = 8'h6E;
	localparam logic [7:0] LT_R      = 8'h72;
	localparam logic [7:0] LT_T      = 8'h74;
	localparam logic [7:0] LT_B      = 8'h62;
	localparam logic [7:0] LT_F      = 8'h66;

	// one classified word in the queue; two means backslash then data
	typedef struct packed {
		logic       two;
		logic [7:0] data;
		logic       present;
		logic       last;
	} entry_t;

	// letter after the backslash, zero when the byte needs no escape
	function automatic logic [7:0] escape_letter(input logic [7:0] b);
		logic [7:0] r;
		case (b)
			CH_QUOTE:  r = CH_QUOTE;
			CH_BSLASH: r = CH_BSLASH;
			CH_NL:     r = LT_N;
			CH_CR:     r = LT_R;
			CH_TAB:    r = LT_T;
			CH_BS:     r = LT_B;
			CH_FF:     r = LT_F;
			default:   r = 8'h00;
		endcase
		return r;
	endfunction

	// byte an escape letter stands for; unknown letters map to themselves
	function automatic logic [7:0] unescape_letter(input logic [7:0] b);
		logic [7:0] r;
		case (b)
			LT_N:    r = CH_NL;
			LT_R:    r = CH_CR;
			LT_T:    r = CH_TAB;
			LT_B:    r = CH_BS;
			LT_F:    r = CH_FF;
			default: r = b;
		endcase
		return r;
	endfunction

endpackage

// ===== src/jsec_front.sv =====
// front end: mode register, pending backslash and classification of input words
module jsec_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               q_full,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	input  logic               cfg_valid,
	input  logic               cfg_data,
	output logic               wr_en,
	output jsec_pkg::entry_t   wr_entry
);

	logic mode_q;
	logic pending_q;
	logic accept;
	logic [7:0] letter;
	logic is_bslash;

	assign accept    = push && !q_full;
	assign letter    = jsec_pkg::escape_letter(in_byte);
	assign is_bslash = (in_byte == jsec_pkg::CH_BSLASH);

	always_comb begin
		wr_entry.two     = 1'b0;
		wr_entry.data    = in_byte;
		wr_entry.present = 1'b1;
		wr_entry.last    = in_last;
		wr_en            = accept;
		if (mode_q == jsec_pkg::MODE_ESCAPE) begin
			if (letter != 8'h00) begin
				wr_entry.two  = 1'b1;
				wr_entry.data = letter;
			end
		end else if (pending_q) begin
			wr_entry.data = jsec_pkg::unescape_letter(in_byte);
		end else if (is_bslash) begin
			if (in_last) begin
				// trailing backslash gives an empty end marker
				wr_entry.data    = 8'h00;
				wr_entry.present = 1'b0;
			end else begin
				wr_en = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= jsec_pkg::MODE_ESCAPE;
			pending_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (accept) begin
				pending_q <= (mode_q == jsec_pkg::MODE_UNESCAPE) && !pending_q
					&& is_bslash && !in_last;
			end
		end
	end

endmodule

// ===== src/jsec_queue.sv =====
// short queue of classified words between front and back
`include "assert_macros.svh"

module jsec_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  jsec_pkg::entry_t   wr_entry,
	input  logic               rd_en,
	output logic               full,
	output logic               rd_valid,
	output jsec_pkg::entry_t   rd_entry
);

	jsec_pkg::entry_t               mem_q [jsec_pkg::QDEPTH];
	logic [jsec_pkg::QPTR_W-1:0]    wptr_q;
	logic [jsec_pkg::QPTR_W-1:0]    rptr_q;
	logic [jsec_pkg::QCNT_W-1:0]    count_q;
	logic                           do_wr;
	logic                           do_rd;

	assign full     = (count_q == jsec_pkg::QCNT_W'(jsec_pkg::QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_entry = mem_q[rptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_count_bound, !(count_q > jsec_pkg::QCNT_W'(jsec_pkg::QDEPTH)), "count over")
	`ASSERT_NEXT(a_fill_moves, do_wr && !do_rd, count_q == $past(count_q) + 1'b1, "no growth")

endmodule

// ===== src/jsec_back.sv =====
// back end: expands queue words into result bytes behind an output register
`include "assert_macros.svh"

module jsec_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_valid,
	input  jsec_pkg::entry_t   rd_entry,
	input  logic               pop,
	output logic               rd_en,
	output logic               empty,
	output logic [7:0]         out_byte,
	output logic               byte_present,
	output logic               out_last
);

	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       present_q;
	logic       last_q;
	logic       phase_q;
	logic       load;
	logic       first_of_two;

	assign load         = !out_valid_q || pop;
	assign first_of_two = rd_entry.two && !phase_q;
	assign rd_en        = load && rd_valid && !first_of_two;

	assign empty        = !out_valid_q;
	assign out_byte     = byte_q;
	assign byte_present = present_q;
	assign out_last     = last_q;

	always_ff @(posedge clk) begin
		if (load && rd_valid) begin
			byte_q    <= first_of_two ? jsec_pkg::CH_BSLASH : rd_entry.data;
			present_q <= rd_entry.two || rd_entry.present;
			last_q    <= first_of_two ? 1'b0 : rd_entry.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= rd_valid;
			if (rd_valid) begin
				phase_q <= first_of_two;
			end
		end
	end

	`ASSERT_ALWAYS(a_phase_entry, !phase_q || (rd_valid && rd_entry.two), "phase without pair")
	`ASSERT_NEXT(a_hold_word, out_valid_q && !pop, out_valid_q, "word dropped without pop")
	`ASSERT_NEXT(a_split_word, load && rd_valid && first_of_two, phase_q && !last_q, "bad pair")

endmodule

// ===== src/json_string_escape_codec_top.sv =====
// top level of the json string escape codec
// Byte stream codec for json strings. Words enter through push/full, one byte
// with its end-of-string flag per word, and leave through empty/pop. A one bit
// mode register on the cfg channel picks the direction: 0 escapes quote,
// backslash, newline, carriage return, tab, backspace and form feed into a
// backslash plus letter, 1 undoes such sequences (an unknown escape keeps the
// byte, a trailing backslash yields an empty word with byte_present low and
// out_last high). The front end takes a word every cycle while its four entry
// queue has room; the back end sends one result byte per cycle from its output
// register while pop is held and the queue is not empty; an escaped byte leaves
// as two bytes. Write the mode only while the codec is idle.
module json_string_escape_codec_top (
	input  logic       clk,
	input  logic       arst_n,
	// input side
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	// result side
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       byte_present,
	output logic       out_last,
	// mode register write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);

	logic             q_full;
	logic             wr_en;
	jsec_pkg::entry_t wr_entry;
	logic             rd_en;
	logic             rd_valid;
	jsec_pkg::entry_t rd_entry;

	// mode register always takes its word
	assign cfg_ready = 1'b1;
	assign full      = q_full;

	// classification and pending backslash
	jsec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.q_full    (q_full),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.wr_en     (wr_en),
		.wr_entry  (wr_entry)
	);

	// decoupling queue
	jsec_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_entry (wr_entry),
		.rd_en    (rd_en),
		.full     (q_full),
		.rd_valid (rd_valid),
		.rd_entry (rd_entry)
	);

	// expansion into result bytes
	jsec_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_valid     (rd_valid),
		.rd_entry     (rd_entry),
		.pop          (pop),
		.rd_en        (rd_en),
		.empty        (empty),
		.out_byte     (out_byte),
		.byte_present (byte_present),
		.out_last     (out_last)
	);

endmodule
